// File: hw/rtl/ovdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovdp_pkg
// Shared widths, record type, control structs and state encodings for the
// overlap dedup packer.
// ----------------------------------------------------------------------------
package ovdp_pkg;

   localparam int unsigned POS_BITS   = 20;
   localparam int unsigned ID_BITS    = 32;

   // error rate: diffs * RATE_SCALE / length, saturated to RATE_BITS
   localparam int unsigned RATE_SCALE = 10000;
   localparam int unsigned SCALE_BITS = $clog2(RATE_SCALE + 1);
   localparam int unsigned RATE_BITS  = 16;
   localparam int unsigned PROD_BITS  = POS_BITS + SCALE_BITS;
   localparam int unsigned OVF_BITS   = POS_BITS + RATE_BITS;
   localparam int unsigned STEP_BITS  = $clog2(RATE_BITS);
   localparam logic [RATE_BITS-1:0] RATE_MAX = {RATE_BITS{1'b1}};

   localparam logic ACTION_RECORD = 1'b0;
   localparam logic ACTION_FLUSH  = 1'b1;

   typedef struct packed {
      logic [ID_BITS-1:0]  a_id;
      logic [ID_BITS-1:0]  b_id;
      logic                forward;
      logic [POS_BITS-1:0] a_begin;
      logic [POS_BITS-1:0] a_end;
      logic [POS_BITS-1:0] a_length;
      logic [POS_BITS-1:0] b_begin;
      logic [POS_BITS-1:0] b_end;
      logic [POS_BITS-1:0] diffs;
   } rec_type;

   typedef struct packed {
      logic start;
      logic ack;
   } rate_ctl_type;

   typedef enum logic [2:0] {
      R_IDLE,
      R_MUL,
      R_CHECK,
      R_DIV,
      R_DONE
   } rate_state_type;

   typedef enum logic {
      C_IDLE,
      C_BUSY
   } core_state_type;

endpackage
`default_nettype wire

// File: hw/rtl/ovdp_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovdp_cache
// One-entry record cache with duplicate compare and emit decision.
// ----------------------------------------------------------------------------
module ovdp_cache (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic             action,
   input  wire ovdp_pkg::rec_type in_rec,
   output logic                  emit,
   output ovdp_pkg::rec_type     held_rec
);

   ovdp_pkg::rec_type held_ff, held_in;

   logic                          same_key;
   logic                          held_full;
   logic                          better;
   logic signed [ovdp_pkg::POS_BITS:0] new_a_span, old_a_span;
   logic signed [ovdp_pkg::POS_BITS:0] new_b_span, old_b_span;

   assign held_rec = held_ff;

   always_comb begin
      new_a_span = $signed({1'b0, in_rec.a_end})   - $signed({1'b0, in_rec.a_begin});
      old_a_span = $signed({1'b0, held_ff.a_end})  - $signed({1'b0, held_ff.a_begin});
      new_b_span = $signed({1'b0, in_rec.b_end})   - $signed({1'b0, in_rec.b_begin});
      old_b_span = $signed({1'b0, held_ff.b_end})  - $signed({1'b0, held_ff.b_begin});

      same_key  = (in_rec.a_id == held_ff.a_id) && (in_rec.b_id == held_ff.b_id) &&
                  (in_rec.forward == held_ff.forward);
      held_full = (held_ff.a_id != '0);

      // first true test decides
      if (new_a_span > old_a_span) begin
         better = 1'b1;
      end else if (new_b_span > old_b_span) begin
         better = 1'b1;
      end else begin
         better = (in_rec.diffs < held_ff.diffs);
      end

      held_in = held_ff;
      emit    = 1'b0;
      if (action == ovdp_pkg::ACTION_FLUSH) begin
         emit    = held_full;
         held_in = '0;
      end else if (same_key) begin
         if (better) begin
            held_in = in_rec;
         end
      end else begin
         emit    = held_full;
         held_in = in_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (fire) begin
         held_ff <= held_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ovdp_rate_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovdp_rate_unit
// Error rate: one multiply, one saturation check, then, unless saturated, a
// radix-2 restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ovdp_rate_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ovdp_pkg::rate_ctl_type            ctl,
   input  wire logic [ovdp_pkg::POS_BITS-1:0]     diffs,
   input  wire logic [ovdp_pkg::POS_BITS-1:0]     len,
   output logic                                   done,
   output logic [ovdp_pkg::RATE_BITS-1:0]         quot
);

   ovdp_pkg::rate_state_type state_ff, state_in;

   logic [ovdp_pkg::POS_BITS-1:0]  diffs_ff, diffs_in;
   logic [ovdp_pkg::POS_BITS-1:0]  len_ff, len_in;
   logic [ovdp_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic [ovdp_pkg::POS_BITS-1:0]  rem_ff, rem_in;
   logic [ovdp_pkg::RATE_BITS-1:0] low_ff, low_in;
   logic [ovdp_pkg::RATE_BITS-1:0] quot_ff, quot_in;
   logic [ovdp_pkg::STEP_BITS-1:0] step_ff, step_in;

   logic [ovdp_pkg::OVF_BITS-1:0]  limit;
   logic                           ovf;
   logic [ovdp_pkg::POS_BITS:0]    trial;
   logic [ovdp_pkg::POS_BITS:0]    trial_sub;
   logic                           ge;

   assign done = (state_ff == ovdp_pkg::R_DONE);
   assign quot = quot_ff;

   always_comb begin
      limit     = {len_ff, ovdp_pkg::RATE_BITS'(0)};
      ovf       = (ovdp_pkg::OVF_BITS'(prod_ff) >= limit);
      trial     = {rem_ff, low_ff[ovdp_pkg::RATE_BITS-1]};
      trial_sub = trial - {1'b0, len_ff};
      ge        = (trial >= {1'b0, len_ff});

      state_in = state_ff;
      diffs_in = diffs_ff;
      len_in   = len_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;

      case (state_ff)
         ovdp_pkg::R_IDLE: begin
            if (ctl.start) begin
               diffs_in = diffs;
               len_in   = len;
               state_in = ovdp_pkg::R_MUL;
            end
         end
         ovdp_pkg::R_MUL: begin
            prod_in  = ovdp_pkg::PROD_BITS'(diffs_ff) *
                       ovdp_pkg::PROD_BITS'(ovdp_pkg::RATE_SCALE);
            state_in = ovdp_pkg::R_CHECK;
         end
         ovdp_pkg::R_CHECK: begin
            // zero length or quotient beyond the field saturates
            if ((len_ff == '0) || ovf) begin
               quot_in  = ovdp_pkg::RATE_MAX;
               state_in = ovdp_pkg::R_DONE;
            end else begin
               rem_in   = ovdp_pkg::POS_BITS'(
                             prod_ff[ovdp_pkg::PROD_BITS-1:ovdp_pkg::RATE_BITS]);
               low_in   = prod_ff[ovdp_pkg::RATE_BITS-1:0];
               quot_in  = '0;
               step_in  = '0;
               state_in = ovdp_pkg::R_DIV;
            end
         end
         ovdp_pkg::R_DIV: begin
            if (ge) begin
               rem_in = trial_sub[ovdp_pkg::POS_BITS-1:0];
            end else begin
               rem_in = trial[ovdp_pkg::POS_BITS-1:0];
            end
            quot_in = {quot_ff[ovdp_pkg::RATE_BITS-2:0], ge};
            low_in  = {low_ff[ovdp_pkg::RATE_BITS-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == ovdp_pkg::STEP_BITS'(ovdp_pkg::RATE_BITS - 1)) begin
               state_in = ovdp_pkg::R_DONE;
            end
         end
         ovdp_pkg::R_DONE: begin
            if (ctl.ack) begin
               state_in = ovdp_pkg::R_IDLE;
            end
         end
         default: begin
            state_in = ovdp_pkg::R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ovdp_pkg::R_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      diffs_ff <= diffs_in;
      len_ff   <= len_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/overlap_dedup_packer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// overlap_dedup_packer_core
// Duplicate-suppressing packer for read-overlap records with error rate.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per accept (req_valid high, req_stall low). An
//   item is an overlap record or, with req_action set, a flush. A record that
//   matches the cached one (same A id, B id, orientation) may replace it and
//   never yields a result; any other record takes its place and pushes a
//   non-empty cache out. A flush pushes a non-empty cache out and empties it.
//   rsp_* presents one emitted record per accept (rsp_valid high, rsp_stall
//   low). rsp_valid holds and the payload stays put while rsp_stall is high.
// Timing:
//   An item that emits nothing does not raise req_stall.
//   An emitting item raises req_stall while the rate unit runs (multiply,
//   saturation check, 16 divider steps, then handing the rate to the output
//   register). rsp_valid rises and req_stall drops at the same edge. A
//   saturated rate skips the radix-2 divider.
//   A waiting result does not block non-emitting items; an emitting item
//   waits in the busy state until the output register frees up, that is
//   while rsp_stall holds the previous result.
// Reset:
//   Synchronous; empties the cache, idles the rate unit, drops rsp_valid.
// ----------------------------------------------------------------------------
module overlap_dedup_packer_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_action,
   input  wire logic [ovdp_pkg::ID_BITS-1:0]  req_read_a_id,
   input  wire logic [ovdp_pkg::ID_BITS-1:0]  req_read_b_id,
   input  wire logic                          req_same_strand,
   input  wire logic [ovdp_pkg::POS_BITS-1:0] req_a_start,
   input  wire logic [ovdp_pkg::POS_BITS-1:0] req_a_stop,
   input  wire logic [ovdp_pkg::POS_BITS-1:0] req_a_length,
   input  wire logic [ovdp_pkg::POS_BITS-1:0] req_b_start,
   input  wire logic [ovdp_pkg::POS_BITS-1:0] req_b_stop,
   input  wire logic [ovdp_pkg::POS_BITS-1:0] req_mismatch_count,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ovdp_pkg::ID_BITS-1:0]       rsp_out_a_id,
   output logic [ovdp_pkg::ID_BITS-1:0]       rsp_out_b_id,
   output logic                               rsp_out_forward,
   output logic [ovdp_pkg::POS_BITS-1:0]      rsp_out_a_begin,
   output logic [ovdp_pkg::POS_BITS-1:0]      rsp_out_a_end,
   output logic [ovdp_pkg::POS_BITS-1:0]      rsp_out_b_begin,
   output logic [ovdp_pkg::POS_BITS-1:0]      rsp_out_b_end,
   output logic [ovdp_pkg::RATE_BITS-1:0]     rsp_error_rate
);

   ovdp_pkg::core_state_type state_ff, state_in;

   ovdp_pkg::rec_type      in_rec;
   ovdp_pkg::rec_type      held_rec;
   ovdp_pkg::rec_type      pend_ff, pend_in;
   ovdp_pkg::rate_ctl_type rate_ctl;
   logic                   emit;
   logic                   fire;
   logic                   rate_done;
   logic [ovdp_pkg::RATE_BITS-1:0] rate_quot;
   logic                   load_out;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ovdp_pkg::ID_BITS-1:0]    a_id_ff, a_id_in;
   logic [ovdp_pkg::ID_BITS-1:0]    b_id_ff, b_id_in;
   logic                            fwd_ff, fwd_in;
   logic [ovdp_pkg::POS_BITS-1:0]   a_begin_ff, a_begin_in;
   logic [ovdp_pkg::POS_BITS-1:0]   a_end_ff, a_end_in;
   logic [ovdp_pkg::POS_BITS-1:0]   b_begin_ff, b_begin_in;
   logic [ovdp_pkg::POS_BITS-1:0]   b_end_ff, b_end_in;
   logic [ovdp_pkg::RATE_BITS-1:0]  rate_ff, rate_in;

   // ready only when no emitted record is in the rate unit
   assign req_stall = (state_ff != ovdp_pkg::C_IDLE);
   assign fire      = req_valid && !req_stall;

   assign in_rec = '{a_id:     req_read_a_id,
                     b_id:     req_read_b_id,
                     forward:  req_same_strand,
                     a_begin:  req_a_start,
                     a_end:    req_a_stop,
                     a_length: req_a_length,
                     b_begin:  req_b_start,
                     b_end:    req_b_stop,
                     diffs:    req_mismatch_count};

   ovdp_cache u_cache (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .action   (req_action),
      .in_rec   (in_rec),
      .emit     (emit),
      .held_rec (held_rec)
   );

   // rate unit takes the outgoing record's diffs and length at start
   ovdp_rate_unit u_rate (
      .clock (clock),
      .reset (reset),
      .ctl   (rate_ctl),
      .diffs (held_rec.diffs),
      .len   (held_rec.a_length),
      .done  (rate_done),
      .quot  (rate_quot)
   );

   always_comb begin
      state_in       = state_ff;
      pend_in        = pend_ff;
      rate_ctl.start = 1'b0;
      rate_ctl.ack   = 1'b0;
      load_out       = 1'b0;

      case (state_ff)
         ovdp_pkg::C_IDLE: begin
            if (fire && emit) begin
               // snapshot the outgoing record before the cache moves on
               pend_in        = held_rec;
               rate_ctl.start = 1'b1;
               state_in       = ovdp_pkg::C_BUSY;
            end
         end
         ovdp_pkg::C_BUSY: begin
            if (rate_done && (!rsp_valid_ff || !rsp_stall)) begin
               load_out     = 1'b1;
               rate_ctl.ack = 1'b1;
               state_in     = ovdp_pkg::C_IDLE;
            end
         end
         default: begin
            state_in = ovdp_pkg::C_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      a_id_in      = a_id_ff;
      b_id_in      = b_id_ff;
      fwd_in       = fwd_ff;
      a_begin_in   = a_begin_ff;
      a_end_in     = a_end_ff;
      b_begin_in   = b_begin_ff;
      b_end_in     = b_end_ff;
      rate_in      = rate_ff;

      if (load_out) begin
         rsp_valid_in = 1'b1;
         a_id_in      = pend_ff.a_id;
         b_id_in      = pend_ff.b_id;
         fwd_in       = pend_ff.forward;
         a_begin_in   = pend_ff.a_begin;
         a_end_in     = pend_ff.a_end;
         // B coordinates in orientation order
         if (pend_ff.forward) begin
            b_begin_in = pend_ff.b_begin;
            b_end_in   = pend_ff.b_end;
         end else begin
            b_begin_in = pend_ff.b_end;
            b_end_in   = pend_ff.b_begin;
         end
         rate_in = rate_quot;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ovdp_pkg::C_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff    <= pend_in;
      a_id_ff    <= a_id_in;
      b_id_ff    <= b_id_in;
      fwd_ff     <= fwd_in;
      a_begin_ff <= a_begin_in;
      a_end_ff   <= a_end_in;
      b_begin_ff <= b_begin_in;
      b_end_ff   <= b_end_in;
      rate_ff    <= rate_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_a_id    = a_id_ff;
   assign rsp_out_b_id    = b_id_ff;
   assign rsp_out_forward = fwd_ff;
   assign rsp_out_a_begin = a_begin_ff;
   assign rsp_out_a_end   = a_end_ff;
   assign rsp_out_b_begin = b_begin_ff;
   assign rsp_out_b_end   = b_end_ff;
   assign rsp_error_rate  = rate_ff;

endmodule
`default_nettype wire

// File: hw/rtl/ovdp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovdp_checker
// Port-level checks for the overlap dedup packer, bound to the top level.
// ----------------------------------------------------------------------------
module ovdp_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [ovdp_pkg::ID_BITS-1:0]  rsp_out_a_id,
   input wire logic [ovdp_pkg::RATE_BITS-1:0] rsp_error_rate
);

   // handshake: a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped under stall");

   // handshake: a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_a_id) && $stable(rsp_error_rate))
      else $error("rsp payload changed under stall");

   // an empty cache is never emitted
   a_no_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_a_id != '0)
      else $error("emitted record with empty A id");

   // reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // req_stall rises only after an accepted item
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("req_stall rose without an accepted item");

endmodule

bind overlap_dedup_packer_core ovdp_checker u_ovdp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_a_id   (rsp_out_a_id),
   .rsp_error_rate (rsp_error_rate)
);
`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for overlap_dedup_packer_core. A short table of directed
// items covers field extremes, the dedup ranking and the cache corner cases;
// then about 625 random items follow. Most are runs of records that share a
// key, and the rest are flushes and noise. Every accepted item goes through a
// cycle-free model of the record cache. Emitted records are checked field by
// field, in order, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_COUNT     = 650;
   localparam int DIRECTED_COUNT = 25;
   localparam int PHASE_ITEMS    = 50;     // random items per idling phase
   localparam int RESET_CYCLES   = 12;
   localparam int DRAIN_CYCLES   = 100;    // wait for stray records after the drain
   localparam int CYCLE_LIMIT    = 200000;
   localparam int REPORT_LIMIT   = 10;

   // one emitted record, as it shows up on the rsp_ side
   typedef struct packed {
      logic [ovdp_pkg::ID_BITS-1:0]   a_id;
      logic [ovdp_pkg::ID_BITS-1:0]   b_id;
      logic                           forward;
      logic [ovdp_pkg::POS_BITS-1:0]  a_begin;
      logic [ovdp_pkg::POS_BITS-1:0]  a_end;
      logic [ovdp_pkg::POS_BITS-1:0]  b_begin;
      logic [ovdp_pkg::POS_BITS-1:0]  b_end;
      logic [ovdp_pkg::RATE_BITS-1:0] rate;
   } emitted_rec_type;

   // one item on the req_ side; rec_type fields map to the ports in order
   typedef struct packed {
      logic              action;
      ovdp_pkg::rec_type rec;
   } req_item_type;

   // how a directed row is checked
   typedef enum logic [1:0] {
      CHK_PREDICT,   // expectation comes from the cache model
      CHK_NONE,      // no record may come out of this item
      CHK_GIVEN      // record typed into the table
   } row_check_type;

   typedef struct packed {
      logic                          action;
      logic [ovdp_pkg::ID_BITS-1:0]  a_id;
      logic [ovdp_pkg::ID_BITS-1:0]  b_id;
      logic                          fwd;
      logic [ovdp_pkg::POS_BITS-1:0] a_start;
      logic [ovdp_pkg::POS_BITS-1:0] a_stop;
      logic [ovdp_pkg::POS_BITS-1:0] a_len;
      logic [ovdp_pkg::POS_BITS-1:0] b_start;
      logic [ovdp_pkg::POS_BITS-1:0] b_stop;
      logic [ovdp_pkg::POS_BITS-1:0] diffs;
      row_check_type                 check;
      emitted_rec_type               given;
   } stim_row_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam emitted_rec_type NO_REC = '0;

   // Directed table. The ranking rows use key A=20, B=21 unless noted; the
   // comments give what the row is after.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // flush straight out of reset: cache empty, junk fields ignored
      '{ovdp_pkg::ACTION_FLUSH, 32'd55, 32'd66, 1'b1, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5,
        20'd6, CHK_NONE, NO_REC},
      // first record only fills the cache
      '{ovdp_pkg::ACTION_RECORD, 32'd1, 32'd2, 1'b1, 20'd0, 20'd100, 20'd1000, 20'd10,
        20'd110, 20'd5, CHK_NONE, NO_REC},
      // all-ones record, reverse strand: pushes out record 1/2, rate 5e4/1000
      '{ovdp_pkg::ACTION_RECORD, '1, '1, 1'b0, '1, '1, '1, '1, 20'd0, '1,
        CHK_GIVEN, '{32'd1, 32'd2, 1'b1, 20'd0, 20'd100, 20'd10, 20'd110, 16'd50}},
      // flush the all-ones record: B swapped by orientation, rate exactly 10000
      '{ovdp_pkg::ACTION_FLUSH, 32'd0, 32'd0, 1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, CHK_GIVEN, '{'1, '1, 1'b0, '1, '1, 20'd0, '1, 16'd10000}},
      // flush on an empty cache
      '{ovdp_pkg::ACTION_FLUSH, '1, '1, 1'b1, '1, '1, '1, '1, '1, '1,
        CHK_NONE, NO_REC},
      // zero A length
      '{ovdp_pkg::ACTION_RECORD, 32'd7, 32'd8, 1'b1, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, CHK_NONE, NO_REC},
      '{ovdp_pkg::ACTION_FLUSH, 32'd0, 32'd0, 1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, CHK_GIVEN, '{32'd7, 32'd8, 1'b1, 20'd0, 20'd0, 20'd0, 20'd0, 16'hFFFF}},
      // quotient 70000 saturates
      '{ovdp_pkg::ACTION_RECORD, 32'd9, 32'd9, 1'b1, 20'd1, 20'd2, 20'd1, 20'd3, 20'd4,
        20'd7, CHK_NONE, NO_REC},
      '{ovdp_pkg::ACTION_FLUSH, 32'd0, 32'd0, 1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, CHK_GIVEN, '{32'd9, 32'd9, 1'b1, 20'd1, 20'd2, 20'd3, 20'd4, 16'hFFFF}},
      // dedup ranking: base, longer A span, longer B span, fewer diffs, worse
      '{ovdp_pkg::ACTION_RECORD, 32'd20, 32'd21, 1'b1, 20'd100, 20'd200, 20'd500, 20'd0,
        20'd50, 20'd10, CHK_PREDICT, NO_REC},
      '{ovdp_pkg::ACTION_RECORD, 32'd20, 32'd21, 1'b1, 20'd100, 20'd300, 20'd500, 20'd0,
        20'd50, 20'd10, CHK_PREDICT, NO_REC},
      '{ovdp_pkg::ACTION_RECORD, 32'd20, 32'd21, 1'b1, 20'd100, 20'd250, 20'd500, 20'd0,
        20'd80, 20'd10, CHK_PREDICT, NO_REC},
      '{ovdp_pkg::ACTION_RECORD, 32'd20, 32'd21, 1'b1, 20'd100, 20'd250, 20'd500, 20'd0,
        20'd80, 20'd3, CHK_PREDICT, NO_REC},
      '{ovdp_pkg::ACTION_RECORD, 32'd20, 32'd21, 1'b1, 20'd100, 20'd250, 20'd500, 20'd0,
        20'd80, 20'd9, CHK_PREDICT, NO_REC},
      // orientation flips: no match, cache goes out
      '{ovdp_pkg::ACTION_RECORD, 32'd20, 32'd21, 1'b0, 20'd100, 20'd250, 20'd500, 20'd0,
        20'd80, 20'd9, CHK_PREDICT, NO_REC},
      // reversed spans: negative, so not better despite huge unsigned value
      '{ovdp_pkg::ACTION_RECORD, 32'd20, 32'd21, 1'b0, 20'd500, 20'd100, 20'd600, 20'd90,
        20'd10, 20'd60, CHK_PREDICT, NO_REC},
      '{ovdp_pkg::ACTION_RECORD, 32'd20, 32'd21, 1'b0, 20'd500, 20'd200, 20'd600, 20'd90,
        20'd10, 20'd1, CHK_PREDICT, NO_REC},
      // -200 beats -300
      '{ovdp_pkg::ACTION_RECORD, 32'd20, 32'd21, 1'b0, 20'd500, 20'd300, 20'd600, 20'd90,
        20'd10, 20'd70, CHK_PREDICT, NO_REC},
      // different B id
      '{ovdp_pkg::ACTION_RECORD, 32'd20, 32'd22, 1'b0, 20'd5, 20'd9, 20'd40, 20'd1, 20'd2,
        20'd3, CHK_PREDICT, NO_REC},
      // A id zero: pushes out the cache, then counts as empty
      '{ovdp_pkg::ACTION_RECORD, 32'd0, 32'd0, 1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, CHK_PREDICT, NO_REC},
      '{ovdp_pkg::ACTION_RECORD, 32'd0, 32'd0, 1'b0, 20'd0, 20'd5, 20'd0, 20'd0, 20'd0,
        20'd0, CHK_PREDICT, NO_REC},
      '{ovdp_pkg::ACTION_FLUSH, 32'd0, 32'd0, 1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, CHK_NONE, NO_REC},
      // zero record against a cleared cache: key matches, not better
      '{ovdp_pkg::ACTION_RECORD, 32'd0, 32'd0, 1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, CHK_PREDICT, NO_REC},
      '{ovdp_pkg::ACTION_RECORD, 32'd0, 32'd5, 1'b1, 20'd3, 20'd4, 20'd5, 20'd6, 20'd7,
        20'd8, CHK_PREDICT, NO_REC},
      '{ovdp_pkg::ACTION_FLUSH, 32'd0, 32'd0, 1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, CHK_PREDICT, NO_REC}
   };

   // ---------------------------------------------------------------- DUT I/O
   logic                           clock              = 1'b0;
   logic                           reset              = 1'b1;
   logic                           req_valid          = 1'b0;
   logic                           req_stall;
   logic                           req_action         = ovdp_pkg::ACTION_RECORD;
   logic [ovdp_pkg::ID_BITS-1:0]   req_read_a_id      = '0;
   logic [ovdp_pkg::ID_BITS-1:0]   req_read_b_id      = '0;
   logic                           req_same_strand    = 1'b0;
   logic [ovdp_pkg::POS_BITS-1:0]  req_a_start        = '0;
   logic [ovdp_pkg::POS_BITS-1:0]  req_a_stop         = '0;
   logic [ovdp_pkg::POS_BITS-1:0]  req_a_length       = '0;
   logic [ovdp_pkg::POS_BITS-1:0]  req_b_start        = '0;
   logic [ovdp_pkg::POS_BITS-1:0]  req_b_stop         = '0;
   logic [ovdp_pkg::POS_BITS-1:0]  req_mismatch_count = '0;
   logic                           rsp_valid;
   logic                           rsp_stall          = 1'b0;
   logic [ovdp_pkg::ID_BITS-1:0]   rsp_out_a_id;
   logic [ovdp_pkg::ID_BITS-1:0]   rsp_out_b_id;
   logic                           rsp_out_forward;
   logic [ovdp_pkg::POS_BITS-1:0]  rsp_out_a_begin;
   logic [ovdp_pkg::POS_BITS-1:0]  rsp_out_a_end;
   logic [ovdp_pkg::POS_BITS-1:0]  rsp_out_b_begin;
   logic [ovdp_pkg::POS_BITS-1:0]  rsp_out_b_end;
   logic [ovdp_pkg::RATE_BITS-1:0] rsp_error_rate;

   overlap_dedup_packer_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_read_a_id      (req_read_a_id),
      .req_read_b_id      (req_read_b_id),
      .req_same_strand    (req_same_strand),
      .req_a_start        (req_a_start),
      .req_a_stop         (req_a_stop),
      .req_a_length       (req_a_length),
      .req_b_start        (req_b_start),
      .req_b_stop         (req_b_stop),
      .req_mismatch_count (req_mismatch_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_a_id       (rsp_out_a_id),
      .rsp_out_b_id       (rsp_out_b_id),
      .rsp_out_forward    (rsp_out_forward),
      .rsp_out_a_begin    (rsp_out_a_begin),
      .rsp_out_a_end      (rsp_out_a_end),
      .rsp_out_b_begin    (rsp_out_b_begin),
      .rsp_out_b_end      (rsp_out_b_end),
      .rsp_error_rate     (rsp_error_rate)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ----------------------------------------------------------- bench state
   ovdp_pkg::rec_type cached_rec = '0;        // model of the one-entry cache
   emitted_rec_type   pending_records [$];    // records owed by the DUT, oldest first
   idle_mode_type     idle_mode = IDLE_NONE;
   int                mismatches = 0;
   int                records_checked = 0;
   int                items_sent = 0;
   int                flushes_sent = 0;
   // current random run: records sharing a key and a coordinate base
   ovdp_pkg::rec_type run_base = '0;
   int                run_left = 0;

   // ------------------------------------------------------------ cache model
   // floor(diffs * 10000 / length), clipped to 16 bits; zero length clips too
   function automatic logic [ovdp_pkg::RATE_BITS-1:0] rate_for(
         input logic [ovdp_pkg::POS_BITS-1:0] diffs,
         input logic [ovdp_pkg::POS_BITS-1:0] len);
      logic [63:0] quotient;
      if (len == '0)
         return ovdp_pkg::RATE_MAX;
      quotient = (64'(diffs) * 64'(ovdp_pkg::RATE_SCALE)) / 64'(len);
      return (quotient > 64'(ovdp_pkg::RATE_MAX)) ? ovdp_pkg::RATE_MAX :
             quotient[ovdp_pkg::RATE_BITS-1:0];
   endfunction

   // stop - start as a signed number; reversed spans come out negative
   function automatic int signed_span(input logic [ovdp_pkg::POS_BITS-1:0] lo,
                                      input logic [ovdp_pkg::POS_BITS-1:0] hi);
      return int'(hi) - int'(lo);
   endfunction

   function automatic emitted_rec_type emitted_from(input ovdp_pkg::rec_type held);
      emitted_rec_type r;
      r.a_id    = held.a_id;
      r.b_id    = held.b_id;
      r.forward = held.forward;
      r.a_begin = held.a_begin;
      r.a_end   = held.a_end;
      // B coordinates go out in orientation order
      r.b_begin = held.forward ? held.b_begin : held.b_end;
      r.b_end   = held.forward ? held.b_end : held.b_begin;
      r.rate    = rate_for(held.diffs, held.a_length);
      return r;
   endfunction

   // Apply one item to the cache model; say whether it pushes a record out.
   task automatic update_cache(input req_item_type item, output bit emits,
                               output emitted_rec_type rec);
      bit key_match;
      bit better;
      emits = 1'b0;
      rec   = NO_REC;
      if (item.action == ovdp_pkg::ACTION_FLUSH) begin
         if (cached_rec.a_id != '0) begin
            emits = 1'b1;
            rec   = emitted_from(cached_rec);
         end
         cached_rec = '0;
      end else begin
         key_match = item.rec.a_id == cached_rec.a_id && item.rec.b_id == cached_rec.b_id &&
                     item.rec.forward == cached_rec.forward;
         if (key_match) begin
            // first test that holds decides: A span, then B span, then diffs
            if (signed_span(item.rec.a_begin, item.rec.a_end) >
                signed_span(cached_rec.a_begin, cached_rec.a_end))
               better = 1'b1;
            else if (signed_span(item.rec.b_begin, item.rec.b_end) >
                     signed_span(cached_rec.b_begin, cached_rec.b_end))
               better = 1'b1;
            else
               better = item.rec.diffs < cached_rec.diffs;
         end else begin
            better = 1'b1;
            // an id-zero cache counts as empty and is dropped silently
            if (cached_rec.a_id != '0) begin
               emits = 1'b1;
               rec   = emitted_from(cached_rec);
            end
         end
         if (better)
            cached_rec = item.rec;
      end
   endtask

   // --------------------------------------------------------------- idling
   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 88;
         IDLE_BOTH:   return $urandom_range(0, 99) < 16;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) < 88;
         IDLE_BOTH:     return $urandom_range(0, 99) < 16;
         default:       return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------- sender
   // Called at a rising edge. Valid is only lowered for an idle cycle, so it
   // stays high across back-to-back items with a single assignment per edge.
   task automatic send_item(input req_item_type item, input row_check_type check,
                            input emitted_rec_type given);
      bit              emits;
      emitted_rec_type predicted;
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= item.action;
      req_read_a_id      <= item.rec.a_id;
      req_read_b_id      <= item.rec.b_id;
      req_same_strand    <= item.rec.forward;
      req_a_start        <= item.rec.a_begin;
      req_a_stop         <= item.rec.a_end;
      req_a_length       <= item.rec.a_length;
      req_b_start        <= item.rec.b_begin;
      req_b_stop         <= item.rec.b_end;
      req_mismatch_count <= item.rec.diffs;
      // req_stall read here is the value the DUT had at this edge
      do
         @(posedge clock);
      while (req_stall);
      update_cache(item, emits, predicted);
      items_sent++;
      if (item.action == ovdp_pkg::ACTION_FLUSH)
         flushes_sent++;
      case (check)
         CHK_PREDICT: if (emits) pending_records.push_back(predicted);
         CHK_GIVEN:   pending_records.push_back(given);
         default:     ;
      endcase
   endtask

   function automatic ovdp_pkg::rec_type random_rec();
      ovdp_pkg::rec_type r;
      r.a_id     = $urandom;
      r.b_id     = $urandom;
      r.forward  = 1'($urandom_range(0, 1));
      r.a_begin  = ovdp_pkg::POS_BITS'($urandom);
      r.a_end    = ovdp_pkg::POS_BITS'($urandom);
      r.a_length = ovdp_pkg::POS_BITS'($urandom);
      r.b_begin  = ovdp_pkg::POS_BITS'($urandom);
      r.b_end    = ovdp_pkg::POS_BITS'($urandom);
      r.diffs    = ovdp_pkg::POS_BITS'($urandom);
      return r;
   endfunction

   // Mostly runs of 1..5 records on one key with coordinates jittered around
   // a base, so the ranking sees ties as well as wins both ways; the rest are
   // flushes (junk fields) and unrelated noise records.
   task automatic next_random_item(output req_item_type item);
      int roll;
      roll        = $urandom_range(0, 99);
      item.action = ovdp_pkg::ACTION_RECORD;
      item.rec    = random_rec();
      if (roll < 8) begin
         item.action = ovdp_pkg::ACTION_FLUSH;
      end else if (roll < 16) begin
         if ($urandom_range(0, 3) == 0)
            item.rec.a_id = '0;
      end else begin
         if (run_left == 0) begin
            run_base = random_rec();
            if ($urandom_range(0, 15) == 0)
               run_base.a_id = '0;
            run_left = $urandom_range(1, 5);
         end
         run_left--;
         item.rec.a_id    = run_base.a_id;
         item.rec.b_id    = run_base.b_id;
         item.rec.forward = run_base.forward;
         item.rec.a_begin = run_base.a_begin + ovdp_pkg::POS_BITS'($urandom_range(0, 3));
         item.rec.a_end   = run_base.a_end + ovdp_pkg::POS_BITS'($urandom_range(0, 3));
         item.rec.b_begin = run_base.b_begin + ovdp_pkg::POS_BITS'($urandom_range(0, 3));
         item.rec.b_end   = run_base.b_end + ovdp_pkg::POS_BITS'($urandom_range(0, 3));
         item.rec.diffs   = ovdp_pkg::POS_BITS'($urandom_range(0, 15));
         case ($urandom_range(0, 9))
            0:       item.rec.a_length = '0;
            // short lengths can saturate
            1:       item.rec.a_length = ovdp_pkg::POS_BITS'($urandom_range(1, 15));
            2:       item.rec.a_length = '1;
            default: ;
         endcase
      end
   endtask

   // -------------------------------------------------------------- receiver
   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("record %0d, %s: expected %0h, got %0h", records_checked, name,
                     want, got);
      end
   endtask

   task automatic check_emitted();
      emitted_rec_type want;
      if (pending_records.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("unexpected record out: a_id %0h b_id %0h", rsp_out_a_id,
                     rsp_out_b_id);
      end else begin
         want = pending_records.pop_front();
         check_field("a_id", 64'(want.a_id), 64'(rsp_out_a_id));
         check_field("b_id", 64'(want.b_id), 64'(rsp_out_b_id));
         check_field("forward", 64'(want.forward), 64'(rsp_out_forward));
         check_field("a_begin", 64'(want.a_begin), 64'(rsp_out_a_begin));
         check_field("a_end", 64'(want.a_end), 64'(rsp_out_a_end));
         check_field("b_begin", 64'(want.b_begin), 64'(rsp_out_b_begin));
         check_field("b_end", 64'(want.b_end), 64'(rsp_out_b_end));
         check_field("error_rate", 64'(want.rate), 64'(rsp_error_rate));
         records_checked++;
      end
   endtask

   // Sample the handshake as it stood at the edge, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_emitted();
      rsp_stall <= receiver_stalls();
   end

   // ---------------------------------------------------------------- watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d records still owed", CYCLE_LIMIT,
               pending_records.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // ------------------------------------------------------------------ main
   initial begin
      req_item_type item;
      int           k;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling so the rows run back to back
      idle_mode = IDLE_NONE;
      for (k = 0; k < DIRECTED_COUNT; k++) begin
         item.action       = DIRECTED_ROWS[k].action;
         item.rec.a_id     = DIRECTED_ROWS[k].a_id;
         item.rec.b_id     = DIRECTED_ROWS[k].b_id;
         item.rec.forward  = DIRECTED_ROWS[k].fwd;
         item.rec.a_begin  = DIRECTED_ROWS[k].a_start;
         item.rec.a_end    = DIRECTED_ROWS[k].a_stop;
         item.rec.a_length = DIRECTED_ROWS[k].a_len;
         item.rec.b_begin  = DIRECTED_ROWS[k].b_start;
         item.rec.b_end    = DIRECTED_ROWS[k].b_stop;
         item.rec.diffs    = DIRECTED_ROWS[k].diffs;
         send_item(item, DIRECTED_ROWS[k].check, DIRECTED_ROWS[k].given);
      end

      // random part; the idling phase rotates every PHASE_ITEMS items
      for (k = 0; k < ITEM_COUNT - DIRECTED_COUNT; k++) begin
         idle_mode = idle_mode_type'((k / PHASE_ITEMS + 1) % 4);
         next_random_item(item);
         send_item(item, CHK_PREDICT, NO_REC);
      end
      req_valid <= 1'b0;

      // drain, then give any stray extra record time to show up
      idle_mode = IDLE_NONE;
      while (pending_records.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items sent (%0d flushes), %0d emitted records compared, %0d mismatches",
               items_sent, flushes_sent, records_checked, mismatches);
      $display("idling phases: none, sender 88%%, receiver 88%%, both 16%%");
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
